// ----- src/lmpf_pkg.sv -----
// Shared types and constants of the LED matrix PWM frame generator.
package lmpf_pkg;

	// Item kinds as they arrive in tuser and travel through the command queue.
	typedef enum logic [1:0] {
		OP_WRITE_PIXEL = 2'd0,
		OP_LOAD_MAP    = 2'd1,
		OP_CLEAR       = 2'd2,
		OP_TICK        = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_ROTATION   = 2'd1;
	localparam logic [1:0] REG_BINARY     = 2'd2;

	// Queue depths between the two halves and ahead of the output port.
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	// One classified command: store address and data already worked out.
	typedef struct packed {
		op_t        kind;
		logic [7:0] addr;
		logic [7:0] data;
	} cmd_t;

	// Configuration seen by the frame walker.
	typedef struct packed {
		logic [7:0] brightness;
		logic [1:0] rotation;
		logic       binary_mode;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
	} out_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_DRAIN
	} back_state_t;

endpackage

// ----- src/lmpf_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module lmpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Old data is read on a same-address write; read data registered every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/lmpf_fifo.sv -----
// Small first-in first-out queue with show-ahead read data.
module lmpf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Entry storage carries no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/lmpf_front.sv -----
// Front end: accepts input beats, classifies them and queues commands.
module lmpf_front #(
	parameter int MATRIX_ROWS = 16,
	parameter int MATRIX_COLS = 16,
	parameter int MAX_LEVEL   = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lmpf_pkg::op_t      in_op,
	input  logic [7:0]         in_x,
	input  logic [7:0]         in_y,
	input  logic               in_lit,
	input  logic [7:0]         in_level,
	input  logic [7:0]         in_slot,
	input  logic [7:0]         in_source,
	output logic               cmd_valid,
	output lmpf_pkg::cmd_t     cmd,
	input  logic               cmd_pop
);
	import lmpf_pkg::*;

	logic        full;
	logic        empty;
	logic        in_bounds;
	logic [11:0] pix_idx;
	logic [7:0]  pix_level;
	logic        keep;
	cmd_t        cmd_w;
	logic [$bits(cmd_t)-1:0] cmd_rd;

	// A pixel write lands at row-major index y * cols + x.
	assign in_bounds = (in_x < 8'(MATRIX_COLS)) && (in_y < 8'(MATRIX_ROWS));
	assign pix_idx   = 12'(in_y) * 12'(MATRIX_COLS) + 12'(in_x);

	// An unlit or zero request stores zero; larger levels are clamped.
	always_comb begin
		if (!in_lit || in_level == 8'd0) begin
			pix_level = 8'd0;
		end else if (in_level > 8'(MAX_LEVEL)) begin
			pix_level = 8'(MAX_LEVEL);
		end else begin
			pix_level = in_level;
		end
	end

	// Build the queued command; an out-of-bounds pixel write is dropped.
	always_comb begin
		cmd_w.kind = in_op;
		cmd_w.addr = 8'd0;
		cmd_w.data = 8'd0;
		keep       = 1'b1;
		case (in_op)
			OP_WRITE_PIXEL: begin
				cmd_w.addr = pix_idx[7:0];
				cmd_w.data = pix_level;
				keep       = in_bounds;
			end
			OP_LOAD_MAP: begin
				cmd_w.addr = in_slot;
				cmd_w.data = in_source;
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	assign in_ready  = !full;
	assign cmd_valid = !empty;
	assign cmd       = cmd_t'(cmd_rd);

	lmpf_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (in_valid && keep),
		.wdata (cmd_w),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_rd),
		.empty (empty)
	);

endmodule

// ----- src/lmpf_back.sv -----
// Back end: executes commands and walks the LED slots to build frame bytes.
module lmpf_back #(
	parameter int MATRIX_ROWS = 16,
	parameter int MATRIX_COLS = 16,
	parameter int MAX_LEVEL   = 255,
	parameter int GRAY_STEPS  = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lmpf_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  lmpf_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_frame_byte,
	output logic           out_last
);
	import lmpf_pkg::*;

	localparam int PIXELS  = MATRIX_ROWS * MATRIX_COLS;
	localparam int PIX_AW  = $clog2(PIXELS);
	localparam int CRW     = $clog2(OUT_DEPTH + 1);
	// Reciprocal of the column count, exact for every index below 256.
	localparam int RECIP_C = (65536 + MATRIX_COLS - 1) / MATRIX_COLS;
	localparam logic [7:0] PWM_STEP = 8'((MAX_LEVEL + 1) / GRAY_STEPS);
	localparam logic signed [10:0] ROWS_S = 11'(MATRIX_ROWS);
	localparam logic signed [10:0] COLS_S = 11'(MATRIX_COLS);
	localparam logic signed [10:0] PIX_S  = 11'(PIXELS);

	back_state_t state_q, state_d;
	logic [PIX_AW-1:0] slot_q;
	logic [CRW-1:0]    credit_q;
	logic [7:0]        pwm_q;
	logic [15:0]       thr_q;
	logic [PIXELS-1:0] pv_q;
	logic [7:0]        acc_q;

	logic issue;
	logic slot_last;
	logic do_write;
	logic do_map;
	logic do_clear;
	logic do_tick;
	logic frame_done;
	logic out_pop;

	// Pipeline valids and slot tags.
	logic       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0] sl_s1, sl_s2, sl_s3, sl_s4, sl_s5;
	logic       last_s1, last_s2, last_s3, last_s4, last_s5;

	// Pipeline payload.
	logic [7:0]  map_rdata;
	logic [20:0] k_recip;
	logic [7:0]  k_s2, k_s3;
	logic [4:0]  i_s2, i_s3;
	logic [4:0]  j_s3;
	logic        oob_s2, oob_s3;
	logic        vld_s4;
	logic [7:0]  pix_rdata;
	logic [7:0]  lvl_s4;
	logic [15:0] prod_s5;
	logic        nz_s5;

	// Source selection signals.
	logic signed [10:0] ks, is_v, js, r1, src1, src2, src3, src;
	logic               bad;
	logic               zero;
	logic [PIX_AW-1:0]  src_idx;

	logic       on;
	logic [7:0] acc_next;
	logic       out_push;
	out_t       out_w;
	logic [$bits(out_t)-1:0] out_rd;
	out_t       out_r;
	logic       out_empty;
	logic       out_full;

	assign slot_last = slot_q == PIX_AW'(PIXELS - 1);
	assign do_write  = cmd_pop && cmd.kind == OP_WRITE_PIXEL;
	assign do_map    = cmd_pop && cmd.kind == OP_LOAD_MAP;
	assign do_clear  = cmd_pop && cmd.kind == OP_CLEAR;
	assign do_tick   = cmd_pop && cmd.kind == OP_TICK;
	assign frame_done = v_s5 && last_s5;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, command pop and slot issue.  A new byte group starts only
	// while the output queue has a free place reserved for it.
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		issue   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.kind == OP_TICK) begin
						state_d = BK_WALK;
					end
				end
			end
			BK_WALK: begin
				issue = (slot_q[2:0] != 3'd0) || (credit_q != '0);
				if (issue && slot_last) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (frame_done) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Slot counter, output credits, PWM counter and pixel valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			credit_q <= CRW'(OUT_DEPTH);
			pwm_q    <= 8'd0;
			pv_q     <= '0;
		end else begin
			if (do_tick) begin
				slot_q <= '0;
			end else if (issue) begin
				slot_q <= slot_q + 1'b1;
			end
			if ((issue && slot_q[2:0] == 3'd0) && !out_pop) begin
				credit_q <= credit_q - 1'b1;
			end else if (out_pop && !(issue && slot_q[2:0] == 3'd0)) begin
				credit_q <= credit_q + 1'b1;
			end
			if (state_q == BK_DRAIN && frame_done && !cfg.binary_mode) begin
				pwm_q <= pwm_q + PWM_STEP;
			end
			if (do_clear) begin
				pv_q <= '0;
			end else if (do_write) begin
				pv_q[cmd.addr[PIX_AW-1:0]] <= 1'b1;
			end
		end
	end

	// The bit is lit when level * brightness reaches (pwm + 1) * max level,
	// which equals the truncated quotient exceeding the counter.
	always_ff @(posedge clk) begin
		thr_q <= 16'((17'(pwm_q) + 17'd1) * 17'(MAX_LEVEL));
	end

	// Position map: loaded by commands, read by the slot walk.
	lmpf_ram #(
		.WIDTH(8),
		.DEPTH(256)
	) u_map_ram (
		.clk  (clk),
		.we   (do_map),
		.waddr(cmd.addr),
		.wdata(cmd.data),
		.raddr(8'(slot_q)),
		.rdata(map_rdata)
	);

	// Pipeline valids and tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sl_s1   <= slot_q[2:0];
		last_s1 <= slot_last;
		sl_s2   <= sl_s1;
		last_s2 <= last_s1;
		sl_s3   <= sl_s2;
		last_s3 <= last_s2;
		sl_s4   <= sl_s3;
		last_s4 <= last_s3;
		sl_s5   <= sl_s4;
		last_s5 <= last_s4;
	end

	// Stage one: divide the mapped index by the column count to get the row.
	assign k_recip = 21'(map_rdata) * 21'(RECIP_C);

	always_ff @(posedge clk) begin
		k_s2   <= map_rdata;
		i_s2   <= k_recip[20:16];
		oob_s2 <= 9'(map_rdata) >= 9'(PIXELS);
	end

	// Stage two: column is the remainder.
	always_ff @(posedge clk) begin
		k_s3   <= k_s2;
		i_s3   <= i_s2;
		j_s3   <= 5'(k_s2 - 8'(i_s2) * 8'(MATRIX_COLS));
		oob_s3 <= oob_s2;
	end

	// Stage three: apply the quarter turns outside binary mode and read the pixel store.
	assign ks   = 11'(k_s3);
	assign is_v = 11'(i_s3);
	assign js   = 11'(j_s3);
	assign r1   = ROWS_S - 11'sd1 - js;
	assign src1 = r1 * COLS_S + is_v;
	assign src2 = PIX_S - 11'sd1 - ks;
	assign src3 = js * COLS_S + COLS_S - 11'sd1 - is_v;

	always_comb begin
		bad = 1'b0;
		src = ks;
		if (!cfg.binary_mode) begin
			case (cfg.rotation)
				2'd1: begin
					src = src1;
					bad = r1 < 11'sd0;
				end
				2'd2: begin
					src = src2;
				end
				2'd3: begin
					src = src3;
					bad = js >= ROWS_S;
				end
				default: begin
					src = ks;
				end
			endcase
		end
		zero = oob_s3 || bad || (src < 11'sd0) || (src >= PIX_S);
		src_idx = zero ? '0 : src[PIX_AW-1:0];
	end

	lmpf_ram #(
		.WIDTH(8),
		.DEPTH(PIXELS)
	) u_pix_ram (
		.clk  (clk),
		.we   (do_write),
		.waddr(cmd.addr[PIX_AW-1:0]),
		.wdata(cmd.data),
		.raddr(src_idx),
		.rdata(pix_rdata)
	);

	always_ff @(posedge clk) begin
		vld_s4 <= pv_q[src_idx] && !zero;
	end

	// Stage four: scale by global brightness.
	assign lvl_s4 = vld_s4 ? pix_rdata : 8'd0;

	always_ff @(posedge clk) begin
		prod_s5 <= 16'(lvl_s4) * 16'(cfg.brightness);
		nz_s5   <= lvl_s4 != 8'd0;
	end

	// Stage five: decide the bit and gather it into the byte, first slot at
	// the top bit.
	assign on       = cfg.binary_mode ? nz_s5 : (prod_s5 >= thr_q);
	assign acc_next = ((sl_s5 == 3'd0) ? 8'd0 : acc_q) | (on ? (8'h80 >> sl_s5) : 8'd0);
	assign out_push = v_s5 && (sl_s5 == 3'd7 || last_s5);

	always_ff @(posedge clk) begin
		if (v_s5) begin
			acc_q <= acc_next;
		end
	end

	// Output queue; credits keep it from overflowing.
	assign out_w.frame_byte = acc_next;
	assign out_w.last       = last_s5;
	assign out_valid        = !out_empty;
	assign out_pop          = out_valid && out_ready;
	assign out_r            = out_t'(out_rd);
	assign out_frame_byte   = out_r.frame_byte;
	assign out_last         = out_r.last;

	lmpf_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_w),
		.full  (out_full),
		.pop   (out_pop),
		.rdata (out_rd),
		.empty (out_empty)
	);

endmodule

// ----- src/led_matrix_pwm_frame_generator_unit.sv -----
// Top level of the LED matrix PWM frame generator: ports, registers, halves.
//
//   Channel  Direction  Handshake                  Payload
//   s_axis   in         s_axis_tvalid/tready       tuser op, tdata pixel and map fields
//   m_axis   out        m_axis_tvalid/tready       tdata frame byte, tlast final byte
//   cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A pixel write, map load or clear is popped and executed by the idle back end. A frame tick
// walks the LED slots one per cycle, while output credits last, through the map and pixel
// store read ports; the back end stays busy while it takes the tick, walks every slot and
// empties the pipeline. Reset clears the pixel valid bits at once, so no clearing pass is
// needed. Input beats are taken while the four-entry command queue has room; an output stall
// halts the walk at byte boundaries once four bytes wait in the output queue or in the
// pipeline.
module led_matrix_pwm_frame_generator_unit #(
	parameter int MATRIX_ROWS = 16,
	parameter int MATRIX_COLS = 16,
	parameter int MAX_LEVEL   = 255,
	parameter int GRAY_STEPS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0: pixel_x[7:0], pixel_y[15:8], lit[16], level[24:17],
	// map_slot[32:25], map_source[40:33], zero fill[47:41].
	input  logic [47:0] s_axis_tdata,
	// Fields from bit 0: op[1:0].
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// Fields from bit 0: frame_byte[7:0].
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import lmpf_pkg::*;

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness  <= 8'd255;
			cfg_q.rotation    <= 2'd0;
			cfg_q.binary_mode <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BRIGHTNESS: cfg_q.brightness  <= cfg_data;
				REG_ROTATION:   cfg_q.rotation    <= cfg_data[1:0];
				REG_BINARY:     cfg_q.binary_mode <= cfg_data[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	lmpf_front #(
		.MATRIX_ROWS(MATRIX_ROWS),
		.MATRIX_COLS(MATRIX_COLS),
		.MAX_LEVEL  (MAX_LEVEL)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (op_t'(s_axis_tuser)),
		.in_x     (s_axis_tdata[7:0]),
		.in_y     (s_axis_tdata[15:8]),
		.in_lit   (s_axis_tdata[16]),
		.in_level (s_axis_tdata[24:17]),
		.in_slot  (s_axis_tdata[32:25]),
		.in_source(s_axis_tdata[40:33]),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	lmpf_back #(
		.MATRIX_ROWS(MATRIX_ROWS),
		.MATRIX_COLS(MATRIX_COLS),
		.MAX_LEVEL  (MAX_LEVEL),
		.GRAY_STEPS (GRAY_STEPS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_frame_byte(m_axis_tdata),
		.out_last      (m_axis_tlast)
	);

endmodule

// ----- verif/tb_led_matrix_pwm_frame_generator_unit.sv -----
// Self-checking bench for the LED matrix PWM frame generator: stream traffic and a frame scoreboard.
module tb_led_matrix_pwm_frame_generator_unit;
	import lmpf_pkg::*;

	localparam int ROWS        = 16;
	localparam int COLS        = 16;
	localparam int MAX_LVL     = 255;
	localparam int GRAY_STEP_N = 64;
	localparam int PIXELS      = ROWS * COLS;
	localparam int FRAME_BYTES = (PIXELS + 7) / 8;
	// Cycles allowed for non-frame commands still queued inside the block.
	localparam int CMD_SETTLE  = 16;
	// One full frame walk plus margin, used once at the end of the run.
	localparam int END_SETTLE  = 320;

	// Tracks pixel levels, the LED map and the PWM phase, and holds the frame beats due.
	class frame_scoreboard;
		logic [7:0]  pixel_levels [PIXELS];
		logic [7:0]  led_map [256];
		logic [7:0]  pwm_phase;
		logic [7:0]  bright;
		logic [1:0]  turns;
		logic        binary_on;
		out_t        beats_due [$];
		int unsigned errors;
		int unsigned beats_seen;

		function new();
			foreach (pixel_levels[i]) pixel_levels[i] = 8'd0;
			foreach (led_map[i]) led_map[i] = 8'd0;
			pwm_phase  = 8'd0;
			bright     = 8'd255;
			turns      = 2'd0;
			binary_on  = 1'b0;
			errors     = 0;
			beats_seen = 0;
		endfunction

		task report(string what);
			$display("ERROR at %0t: %s", $time, what);
			errors++;
		endtask

		function void set_register(logic [1:0] idx, logic [7:0] value);
			case (idx)
				REG_BRIGHTNESS: bright = value;
				REG_ROTATION:   turns = value[1:0];
				REG_BINARY:     binary_on = value[0];
				default: ;
			endcase
		endfunction

		// Level at pixel index k once the picture is turned by the set number of quarter turns.
		function int unsigned turned_level(int k);
			int row;
			int col;
			int src;
			row = k / COLS;
			col = k % COLS;
			case (turns)
				2'd1: src = (ROWS - 1 - col) * COLS + row;
				2'd2: src = PIXELS - 1 - k;
				2'd3: src = col * COLS + (COLS - 1 - row);
				default: src = k;
			endcase
			if (src < 0 || src >= PIXELS) return 0;
			return pixel_levels[src];
		endfunction

		// Walk every LED slot and queue the resulting frame bytes.
		function void render_frame();
			logic [7:0]  bytes [FRAME_BYTES];
			int          src;
			int unsigned scaled;
			logic        on;
			out_t        beat;
			foreach (bytes[i]) bytes[i] = 8'd0;
			for (int s = 0; s < PIXELS; s++) begin
				src = led_map[s];
				if (binary_on) begin
					on = (src < PIXELS) && (pixel_levels[src] != 8'd0);
				end else begin
					scaled = (src < PIXELS) ? turned_level(src) : 0;
					scaled = (scaled * bright) / MAX_LVL;
					on = scaled > pwm_phase;
				end
				if (on) bytes[s / 8][7 - (s % 8)] = 1'b1;
			end
			if (!binary_on) pwm_phase = pwm_phase + 8'((MAX_LVL + 1) / GRAY_STEP_N);
			for (int b = 0; b < FRAME_BYTES; b++) begin
				beat.frame_byte = bytes[b];
				beat.last = (b == FRAME_BYTES - 1);
				beats_due.insert(beats_due.size(), beat);
			end
		endfunction

		// Apply one accepted input beat to the tracked state.
		function void note_item(op_t kind, logic [7:0] x, logic [7:0] y, logic lit_b,
				logic [7:0] lvl, logic [7:0] slot, logic [7:0] src);
			case (kind)
				OP_WRITE_PIXEL: begin
					if (x < COLS && y < ROWS) begin
						if (!lit_b || lvl == 8'd0) pixel_levels[y * COLS + x] = 8'd0;
						else pixel_levels[y * COLS + x] = (lvl > MAX_LVL) ? 8'(MAX_LVL) : lvl;
					end
				end
				OP_LOAD_MAP: led_map[slot] = src;
				OP_CLEAR: foreach (pixel_levels[i]) pixel_levels[i] = 8'd0;
				OP_TICK: render_frame();
				default: ;
			endcase
		endfunction

		// Compare one output beat with the oldest frame byte due.
		task check_beat(logic [7:0] got_byte, logic got_last);
			out_t due;
			if (beats_due.size() == 0) begin
				report($sformatf("unexpected output beat byte=%02h last=%0b", got_byte, got_last));
			end else begin
				due = beats_due.pop_front();
				if (got_byte !== due.frame_byte)
					report($sformatf("beat %0d: frame byte %02h, wanted %02h",
						beats_seen, got_byte, due.frame_byte));
				if (got_last !== due.last)
					report($sformatf("beat %0d: last %0b, wanted %0b",
						beats_seen, got_last, due.last));
			end
			beats_seen++;
		endtask

		function int unsigned pending();
			return beats_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	int unsigned stall_odds;
	int unsigned hold_left;
	frame_scoreboard board;

	led_matrix_pwm_frame_generator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver back-pressure: random stall bursts while stall_odds is set.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
			hold_left <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Every output beat is checked against the scoreboard as it is taken.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_beat(m_axis_tdata, m_axis_tlast);
	end

	// Hard limit on the run length.
	initial begin
		#50_000_000;
		$display("led_matrix_pwm_frame_generator_unit: mismatch");
		$finish;
	end

	// Offer one input beat and record it once taken; valid stays high for a following beat.
	task automatic send_item(op_t kind, logic [7:0] x, logic [7:0] y, logic lit_b,
			logic [7:0] lvl, logic [7:0] slot, logic [7:0] src);
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {7'd0, src, slot, lvl, lit_b, y, x};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		board.note_item(kind, x, y, lit_b, lvl, slot, src);
	endtask

	task automatic pause_sender(int unsigned cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold the input off until every frame byte due has come out, then let the block settle.
	task automatic drain_and_settle(int unsigned settle);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write all three registers back to back on the configuration channel.
	task automatic apply_setting(logic [7:0] bright_v, logic [1:0] turns_v, logic binary_v);
		logic [7:0] values [3];
		logic [1:0] idx [3];
		values[0] = bright_v;
		values[1] = {6'd0, turns_v};
		values[2] = {7'd0, binary_v};
		idx[0] = REG_BRIGHTNESS;
		idx[1] = REG_ROTATION;
		idx[2] = REG_BINARY;
		for (int r = 0; r < 3; r++) begin
			cfg_index <= idx[r];
			cfg_data  <= values[r];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			board.set_register(idx[r], values[r]);
		end
		cfg_valid <= 1'b0;
	endtask

	// One random beat: tick_pct percent ticks, rare clears, some map loads, else mostly in-bounds writes.
	task automatic random_item(int unsigned tick_pct);
		int unsigned roll;
		op_t         kind;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  lvl;
		logic        lit_b;
		roll = $urandom_range(0, 99);
		if (roll < tick_pct) kind = OP_TICK;
		else if (roll < tick_pct + 3) kind = OP_CLEAR;
		else if (roll < tick_pct + 18) kind = OP_LOAD_MAP;
		else kind = OP_WRITE_PIXEL;
		x = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, COLS - 1)) : 8'($urandom);
		y = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, ROWS - 1)) : 8'($urandom);
		case ($urandom_range(0, 9))
			0: lvl = 8'd0;
			1: lvl = 8'd255;
			default: lvl = 8'($urandom);
		endcase
		lit_b = ($urandom_range(0, 9) != 0);
		send_item(kind, x, y, lit_b, lvl, 8'($urandom), 8'($urandom));
	endtask

	// One phase: settle, set the registers, then a stretch of random beats with its own idling.
	task automatic run_phase(logic [7:0] bright_v, logic [1:0] turns_v, logic binary_v,
			int unsigned count, int unsigned tick_pct, int unsigned gap_odds,
			int unsigned stall_v, bit hold_mid);
		drain_and_settle(CMD_SETTLE);
		apply_setting(bright_v, turns_v, binary_v);
		stall_odds = stall_v;
		for (int n = 0; n < count; n++) begin
			if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
				pause_sender($urandom_range(1, 17));
			if (hold_mid && n == count / 2)
				drain_and_settle(0);
			random_item(tick_pct);
		end
	endtask

	// Main sequence.
	initial begin
		board = new();
		stall_odds = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_WRITE_PIXEL;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BRIGHTNESS;
		cfg_data <= 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every slot needs a map entry before the first tick; start from the identity map.
		apply_setting(8'd255, 2'd0, 1'b0);
		for (int s = 0; s < 256; s++)
			send_item(OP_LOAD_MAP, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
				8'(s), 8'(s));

		// Directed: corners, level extremes, unlit and zero writes, out-of-bounds writes.
		send_item(OP_WRITE_PIXEL, 8'd0, 8'd0, 1'b1, 8'd255, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd15, 8'd0, 1'b1, 8'd1, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd0, 8'd15, 1'b1, 8'd128, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd15, 8'd15, 1'b1, 8'd254, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd3, 8'd4, 1'b0, 8'd200, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd5, 8'd5, 1'b1, 8'd0, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd16, 8'd0, 1'b1, 8'd255, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd0, 8'd16, 1'b1, 8'd255, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255);
		send_item(OP_WRITE_PIXEL, 8'd128, 8'd3, 1'b1, 8'd77, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0);
		// Re-point the first and last slots at the opposite corners.
		send_item(OP_LOAD_MAP, 8'd0, 8'd0, 1'b0, 8'd0, 8'd255, 8'd0);
		send_item(OP_LOAD_MAP, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd255);
		send_item(OP_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0);
		send_item(OP_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd7, 8'd9, 1'b1, 8'd77, 8'd0, 8'd0);
		send_item(OP_WRITE_PIXEL, 8'd9, 8'd7, 1'b1, 8'd255, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0);

		// Random phases over the register extremes; tick-heavy phases make the PWM phase wrap.
		run_phase(8'd255, 2'd1, 1'b0, 15, 20, 6, 8, 1'b0);
		run_phase(8'd0, 2'd2, 1'b0, 10, 20, 0, 0, 1'b0);
		run_phase(8'd128, 2'd3, 1'b0, 30, 95, 4, 3, 1'b1);
		run_phase(8'd255, 2'd0, 1'b1, 10, 20, 8, 12, 1'b0);
		run_phase(8'd1, 2'd3, 1'b1, 10, 20, 5, 5, 1'b0);
		run_phase(8'd200, 2'd2, 1'b0, 30, 95, 3, 4, 1'b0);
		run_phase(8'd255, 2'd3, 1'b0, 15, 20, 10, 6, 1'b0);
		// Final stretch at full rate on both sides.
		run_phase(8'd255, 2'd0, 1'b0, 15, 20, 0, 0, 1'b0);

		drain_and_settle(END_SETTLE);
		if (board.errors == 0) begin
			$display("led_matrix_pwm_frame_generator_unit: match");
		end else begin
			$display("led_matrix_pwm_frame_generator_unit: mismatch");
		end
		$finish;
	end

endmodule
